// ===== sv/tbc_pkg.sv =====
`default_nettype none

package tbc_pkg;

   // Result fields
   localparam int NORMAL_WIDTH    = 34;
   localparam int NUM_NORMALS     = 3;
   localparam int RSP_TDATA_WIDTH = ((NUM_NORMALS * NORMAL_WIDTH + 7) / 8) * 8;

   // Vertex fields per triangle
   localparam int NUM_COORDS = 9;

   // Configuration port
   localparam int CSR_ADDR_WIDTH = 2;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_CAMERA_X = 2'd0,
      CSR_CAMERA_Y = 2'd1,
      CSR_CAMERA_Z = 2'd2
   } csr_index_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// ===== sv/tbc_front.sv =====
`default_nettype none

// Front: takes triangles, holds camera registers, forms edge and eye vectors.
module tbc_front #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [((tbc_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  wire logic                                   csr_we,
   input  wire logic [tbc_pkg::CSR_ADDR_WIDTH-1:0]     csr_addr,
   input  wire logic [COORD_WIDTH-1:0]                 csr_wdata,
   input  wire tbc_pkg::q_status_type                  q_status,
   output logic                                        fr_valid,
   output logic [9*(COORD_WIDTH+1)-1:0]                fr_data
);

   localparam int W  = COORD_WIDTH;
   localparam int DW = COORD_WIDTH + 1;

   logic signed [W-1:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic signed [W-1:0] v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z;
   logic                valid_ff;
   logic [9*DW-1:0]     data_ff, data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= '0;
      end else if (csr_we) begin
         unique case (tbc_pkg::csr_index_type'(csr_addr))
            tbc_pkg::CSR_CAMERA_X: cam_x_ff <= csr_wdata;
            tbc_pkg::CSR_CAMERA_Y: cam_y_ff <= csr_wdata;
            tbc_pkg::CSR_CAMERA_Z: cam_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign v0x = $signed(req_tdata[0*W +: W]);
   assign v0y = $signed(req_tdata[1*W +: W]);
   assign v0z = $signed(req_tdata[2*W +: W]);
   assign v1x = $signed(req_tdata[3*W +: W]);
   assign v1y = $signed(req_tdata[4*W +: W]);
   assign v1z = $signed(req_tdata[5*W +: W]);
   assign v2x = $signed(req_tdata[6*W +: W]);
   assign v2y = $signed(req_tdata[7*W +: W]);
   assign v2z = $signed(req_tdata[8*W +: W]);

   // order: ax ay az bx by bz ex ey ez, lowest first
   always_comb begin
      data_in[0*DW +: DW] = DW'(v0x) - DW'(v1x);
      data_in[1*DW +: DW] = DW'(v0y) - DW'(v1y);
      data_in[2*DW +: DW] = DW'(v0z) - DW'(v1z);
      data_in[3*DW +: DW] = DW'(v0x) - DW'(v2x);
      data_in[4*DW +: DW] = DW'(v0y) - DW'(v2y);
      data_in[5*DW +: DW] = DW'(v0z) - DW'(v2z);
      data_in[6*DW +: DW] = DW'(v0x) - DW'(cam_x_ff);
      data_in[7*DW +: DW] = DW'(v0y) - DW'(cam_y_ff);
      data_in[8*DW +: DW] = DW'(v0z) - DW'(cam_z_ff);
   end

   assign req_tready = !valid_ff || !q_status.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         data_ff <= data_in;
      end
   end

   assign fr_valid = valid_ff;
   assign fr_data  = data_ff;

endmodule

`default_nettype wire

// ===== sv/tbc_queue.sv =====
`default_nettype none

// Small FIFO between front and back.
module tbc_queue #(
   parameter int WIDTH = 153,
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire logic [WIDTH-1:0]  push_data,
   input  wire logic              pop_ready,
   output logic [WIDTH-1:0]       pop_data,
   output tbc_pkg::q_status_type  q_status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign q_status.full  = (count_ff == CW'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign push = push_valid && !q_status.full;
   assign pop  = pop_ready && !q_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];

   // occupancy bookkeeping
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers apart while empty");

endmodule

`default_nettype wire

// ===== sv/tbc_back.sv =====
`default_nettype none

// Back: cross product, split dot product, sign test, output register.
module tbc_back #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire tbc_pkg::q_status_type                  q_status,
   input  wire logic [9*(COORD_WIDTH+1)-1:0]           pop_data,
   output logic                                        pop_ready,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [tbc_pkg::RSP_TDATA_WIDTH-1:0]         rsp_tdata,
   output logic                                        rsp_tuser
);

   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;        // edge / eye vector
   localparam int P1  = 2 * DW;       // cross products
   localparam int NW  = P1 + 1;       // exact normal
   localparam int L   = W + 2;        // low split of normal
   localparam int HW  = NW - L;       // high split of normal
   localparam int HP  = HW + DW;
   localparam int LP  = L + 1 + DW;
   localparam int HS  = HP + 2;
   localparam int LS  = LP + 2;
   localparam int DT  = 3 * W + 7;
   localparam int NRM = tbc_pkg::NORMAL_WIDTH;

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   logic signed [DW-1:0] ax, ay, az, bx, by, bz;
   logic signed [DW-1:0] e1_ff [3];
   logic signed [DW-1:0] e2_ff [3];
   logic signed [P1-1:0] p_ff [6];
   logic signed [P1-1:0] p_in [6];
   logic signed [NW-1:0] n_ff [3];
   logic signed [NW-1:0] n_in [3];
   logic signed [HP-1:0] hi_ff [3];
   logic signed [HP-1:0] hi_in [3];
   logic signed [LP-1:0] lo_ff [3];
   logic signed [LP-1:0] lo_in [3];
   logic signed [HS-1:0] hs_ff, hs_in;
   logic signed [LS-1:0] ls_ff, ls_in;
   logic signed [DT-1:0] dot;
   logic [3*NRM-1:0]     nf3_ff, nf3_in, nf4_ff, nf_out_ff;
   logic                 culled_ff, culled_in;

   // whole pipe advances unless the output is held
   assign en        = !v5_ff || rsp_tready;
   assign pop_ready = en;

   assign ax = $signed(pop_data[0*DW +: DW]);
   assign ay = $signed(pop_data[1*DW +: DW]);
   assign az = $signed(pop_data[2*DW +: DW]);
   assign bx = $signed(pop_data[3*DW +: DW]);
   assign by = $signed(pop_data[4*DW +: DW]);
   assign bz = $signed(pop_data[5*DW +: DW]);

   always_comb begin
      p_in[0] = P1'(ay) * P1'(bz);
      p_in[1] = P1'(az) * P1'(by);
      p_in[2] = P1'(az) * P1'(bx);
      p_in[3] = P1'(ax) * P1'(bz);
      p_in[4] = P1'(ax) * P1'(by);
      p_in[5] = P1'(ay) * P1'(bx);
   end

   always_comb begin
      n_in[0] = NW'(p_ff[0]) - NW'(p_ff[1]);
      n_in[1] = NW'(p_ff[2]) - NW'(p_ff[3]);
      n_in[2] = NW'(p_ff[4]) - NW'(p_ff[5]);
   end

   // N.E = 2^L * sum(nh*e) + sum(nl*e), nl taken unsigned
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hi_in[k] = HP'($signed(n_ff[k][NW-1:L])) * HP'(e2_ff[k]);
         lo_in[k] = LP'($signed({1'b0, n_ff[k][L-1:0]})) * LP'(e2_ff[k]);
         nf3_in[k*NRM +: NRM] = NRM'(n_ff[k]);
      end
   end

   assign hs_in = HS'(hi_ff[0]) + HS'(hi_ff[1]) + HS'(hi_ff[2]);
   assign ls_in = LS'(lo_ff[0]) + LS'(lo_ff[1]) + LS'(lo_ff[2]);

   assign dot       = (DT'(hs_ff) <<< L) + DT'(ls_ff);
   assign culled_in = !dot[DT-1] && (|dot);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= !q_status.empty;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 6; k++) begin
            p_ff[k] <= p_in[k];
         end
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= $signed(pop_data[(6+k)*DW +: DW]);
            e2_ff[k] <= e1_ff[k];
            n_ff[k]  <= n_in[k];
            hi_ff[k] <= hi_in[k];
            lo_ff[k] <= lo_in[k];
         end
         nf3_ff    <= nf3_in;
         hs_ff     <= hs_in;
         ls_ff     <= ls_in;
         nf4_ff    <= nf3_ff;
         nf_out_ff <= nf4_ff;
         culled_ff <= culled_in;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = tbc_pkg::RSP_TDATA_WIDTH'(nf_out_ff);
   assign rsp_tuser  = culled_ff;

endmodule

`default_nettype wire

// ===== sv/triangle_backface_cull.sv =====
// Triangle back-face cull.
// req_ channel: one triangle per transfer, nine signed COORD_WIDTH-bit
//   coordinates v0..v2 (x, y, z each) packed in req_tdata.
// rsp_ channel: one transfer per triangle, in order. rsp_tdata carries the
//   unnormalized face normal (v0-v1) x (v0-v2) as three signed 34-bit
//   fields (wrapped to 34 bits); rsp_tuser is culled, set when the normal
//   dotted with (v0 - camera) is strictly positive, computed exactly.
// csr_ port: camera x/y/z at indexes 0..2, written when csr_we is high.
//   Write only while no triangle is in flight. Unused indexes are ignored.
// Throughput: one triangle per cycle, sustained while rsp_ is not stalled.
//   Path from a req_ transfer to rsp_tvalid: front register (loads at the
//   transfer edge), queue write, then 5 back stages: cross products, normal,
//   split dot products, sums, sign test / output register.
// Reset (synchronous): camera returns to the origin, queue and pipe empty.
// A stalled rsp_ side freezes the back pipe; the front keeps taking
//   triangles until the queue fills, then drops req_tready.
`default_nettype none

module triangle_backface_cull #(
   parameter int COORD_WIDTH = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // fields from bit 0: v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z, zero pad
   input  wire logic [((tbc_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // fields from bit 0: normal_x normal_y normal_z, zero pad
   output logic [tbc_pkg::RSP_TDATA_WIDTH-1:0]         rsp_tdata,
   // fields from bit 0: culled
   output logic                                        rsp_tuser,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   input  wire logic                                   csr_we,
   input  wire logic [tbc_pkg::CSR_ADDR_WIDTH-1:0]     csr_addr,
   input  wire logic [COORD_WIDTH-1:0]                 csr_wdata
);

   // queue entry: edge vectors A, B and eye vector E
   localparam int QW = 9 * (COORD_WIDTH + 1);

   tbc_pkg::q_status_type q_status;
   logic                  fr_valid;
   logic [QW-1:0]         fr_data;
   logic [QW-1:0]         pop_data;
   logic                  pop_ready;

   tbc_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .fr_valid   (fr_valid),
      .fr_data    (fr_data)
   );

   tbc_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_data  (fr_data),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .q_status   (q_status)
   );

   tbc_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== dv/triangle_backface_cull_tb.sv =====
`timescale 1ns / 1ps

module triangle_backface_cull_tb;

   // ------------------------------------------------------------------
   // Block geometry
   // ------------------------------------------------------------------
   localparam int COORD_WIDTH     = 16;
   localparam int REQ_TDATA_WIDTH = ((tbc_pkg::NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
   localparam int COORD_MAX       = 2 ** (COORD_WIDTH - 1) - 1;
   localparam int COORD_MIN       = -(2 ** (COORD_WIDTH - 1));

   // index 3 decodes to nothing; writes there must not touch the camera
   localparam logic [tbc_pkg::CSR_ADDR_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;

   // ------------------------------------------------------------------
   // Run shape
   // ------------------------------------------------------------------
   localparam int DUT_LATENCY     = 6;     // req_ transfer edge to rsp_tvalid
   localparam int NUM_DIRECTED    = 17;
   localparam int NUM_PHASES      = 8;     // camera settings after the directed part
   localparam int TRIS_PER_PHASE  = 250;
   localparam int HOLD_OFF_CYCLES = 300;   // long rsp_ stall, fills the queue
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transfer on either side

   // camera settings per phase; later phases draw random positions
   localparam int PHASE_CAM_MAX   = 1;
   localparam int PHASE_CAM_MIN   = 2;
   localparam int PHASE_CAM_MIXED = 3;
   localparam int PHASE_PRESSURE  = 4;

   typedef logic signed [COORD_WIDTH-1:0]                     coord_type;
   typedef logic [tbc_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0]   triangle_type;  // v0_x in [0]
   typedef logic signed [127:0]                               wide_type;

   typedef struct packed {
      logic                                                        culled;
      logic [tbc_pkg::NUM_NORMALS-1:0][tbc_pkg::NORMAL_WIDTH-1:0]  normal;   // x in [0]
   } cull_result_type;

   // one line of the directed table; result is used only when known is set
   typedef struct packed {
      triangle_type    vertices;
      logic            known;
      cull_result_type result;
   } stim_row_type;

   typedef enum int {
      SHAPE_ANY,
      SHAPE_SMALL,
      SHAPE_DEGENERATE,
      SHAPE_COLLINEAR,
      SHAPE_EYE_AT_V0,
      SHAPE_EXTREME
   } tri_shape_type;

   // ------------------------------------------------------------------
   // DUT ports, inputs all known from time zero
   // ------------------------------------------------------------------
   logic                                 clock      = 1'b0;
   logic                                 reset      = 1'b1;
   // fields from bit 0: v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z
   logic [REQ_TDATA_WIDTH-1:0]           req_tdata  = '0;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   // fields from bit 0: normal_x normal_y normal_z, zero pad
   logic [tbc_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata;
   // fields from bit 0: culled
   logic                                 rsp_tuser;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic                                 csr_we     = 1'b0;
   logic [tbc_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr   = '0;
   coord_type                            csr_wdata  = '0;

   // ------------------------------------------------------------------
   // Testbench state
   // ------------------------------------------------------------------
   coord_type        camera_pos [3] = '{0, 0, 0};   // shadow of the camera regs
   cull_result_type  pending_culls [$];             // predicted, oldest first
   stim_row_type     directed_rows [NUM_DIRECTED];
   string            axis_name [3] = '{"x", "y", "z"};
   int               mismatch_count  = 0;
   int               checked_results = 0;
   bit               req_burst = 1'b0;              // no-gap stretches, sender
   bit               rsp_burst = 1'b0;              // no-stall stretches, receiver
   bit               hold_off_pending = 1'b0;       // main asks receiver for a long stall

   triangle_backface_cull #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor: normal = (v0-v1) x (v0-v2), culled when normal . (v0-cam)
   // is strictly positive. Everything held at 128 bits so the dot product
   // is exact; the normal fields carry the low NORMAL_WIDTH bits.
   // ------------------------------------------------------------------
   function automatic cull_result_type predict_cull(input triangle_type t);
      wide_type        p [3][3];
      wide_type        a [3];
      wide_type        b [3];
      wide_type        n [3];
      wide_type        dot;
      cull_result_type r;
      for (int v = 0; v < 3; v++)
         for (int c = 0; c < 3; c++)
            p[v][c] = wide_type'($signed(t[3 * v + c]));
      for (int c = 0; c < 3; c++) begin
         a[c] = p[0][c] - p[1][c];
         b[c] = p[0][c] - p[2][c];
      end
      n[0] = a[1] * b[2] - a[2] * b[1];
      n[1] = a[2] * b[0] - a[0] * b[2];
      n[2] = a[0] * b[1] - a[1] * b[0];
      dot  = '0;
      for (int c = 0; c < 3; c++) begin
         r.normal[c] = n[c][tbc_pkg::NORMAL_WIDTH-1:0];
         dot += n[c] * (p[0][c] - wide_type'(camera_pos[c]));
      end
      r.culled = (dot > 0);
      return r;
   endfunction

   // table row builder; the trailing fields are filled only for rows whose
   // result is obvious by inspection
   function automatic stim_row_type row(input int x0, y0, z0, x1, y1, z1, x2, y2, z2,
                                        input bit known = 1'b0,
                                        input longint nx = 0, ny = 0, nz = 0,
                                        input bit culled = 1'b0);
      int           c [tbc_pkg::NUM_COORDS];
      stim_row_type r;
      c = '{x0, y0, z0, x1, y1, z1, x2, y2, z2};
      foreach (c[i]) r.vertices[i] = coord_type'(c[i]);
      r.known         = known;
      r.result.normal = {tbc_pkg::NORMAL_WIDTH'(nz), tbc_pkg::NORMAL_WIDTH'(ny),
                         tbc_pkg::NORMAL_WIDTH'(nx)};
      r.result.culled = culled;
      return r;
   endfunction

   // Random triangle. Half are unconstrained; the rest aim at the corners
   // of the math: tiny triangles, zero-area ones, eye on v0, rail values.
   function automatic triangle_type random_triangle();
      triangle_type  t;
      tri_shape_type shape;
      int            pick;
      int            d;
      pick = $urandom_range(0, 15);
      if (pick < 8)       shape = SHAPE_ANY;
      else if (pick < 10) shape = SHAPE_SMALL;
      else if (pick < 12) shape = SHAPE_DEGENERATE;
      else if (pick < 13) shape = SHAPE_COLLINEAR;
      else if (pick < 14) shape = SHAPE_EYE_AT_V0;
      else                shape = SHAPE_EXTREME;
      foreach (t[i]) t[i] = coord_type'($urandom);
      case (shape)
         SHAPE_SMALL: begin
            for (int c = 0; c < 3; c++) begin
               t[3 + c] = coord_type'(t[c] + $urandom_range(0, 511) - 256);
               t[6 + c] = coord_type'(t[c] + $urandom_range(0, 511) - 256);
            end
         end
         SHAPE_DEGENERATE: begin
            pick = $urandom_range(0, 2);
            for (int c = 0; c < 3; c++)
               case (pick)
                  0:       t[3 + c] = t[c];
                  1:       t[6 + c] = t[c];
                  default: t[6 + c] = t[3 + c];
               endcase
         end
         SHAPE_COLLINEAR: begin
            // kept away from the rails so v0 + 2d cannot wrap
            for (int c = 0; c < 3; c++) begin
               d        = $urandom_range(0, 2047) - 1024;
               t[c]     = coord_type'($urandom_range(0, 32767) - 16384);
               t[3 + c] = coord_type'(t[c] + d);
               t[6 + c] = coord_type'(t[c] + 2 * d);
            end
         end
         SHAPE_EYE_AT_V0: begin
            for (int c = 0; c < 3; c++) t[c] = camera_pos[c];
         end
         SHAPE_EXTREME: begin
            foreach (t[i])
               case ($urandom_range(0, 4))
                  0:       t[i] = coord_type'(COORD_MAX);
                  1:       t[i] = coord_type'(COORD_MIN);
                  2:       t[i] = '0;
                  3:       t[i] = '1;
                  default: t[i] = coord_type'(1);
               endcase
         end
         default: ;
      endcase
      return t;
   endfunction

   // idle cycles before the next transfer; flips in and out of no-gap runs
   function automatic int draw_gap(inout bit burst);
      if ($urandom_range(0, 31) == 0) burst = !burst;
      return burst ? 0 : $urandom_range(0, 15);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at result %0d: %s", checked_results, msg);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Sender side. tvalid is dropped only across a real gap, so a held
   // valid never sees two NBAs in one step.
   // ------------------------------------------------------------------
   task automatic send_triangle(input triangle_type t, input cull_result_type want,
                                input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= REQ_TDATA_WIDTH'(t);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_culls.insert(pending_culls.size(), want);
   endtask

   // stop offering and let every predicted result come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_culls.size() != 0) @(posedge clock);
   endtask

   // caller lowers csr_we after the last write of a batch
   task automatic write_csr(input logic [tbc_pkg::CSR_ADDR_WIDTH-1:0] idx,
                            input coord_type value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx <= tbc_pkg::CSR_CAMERA_Z) camera_pos[idx] = value;
   endtask

   task automatic set_camera(input int phase);
      coord_type cam [3];
      foreach (cam[c])
         case (phase)
            PHASE_CAM_MAX:   cam[c] = coord_type'(COORD_MAX);
            PHASE_CAM_MIN:   cam[c] = coord_type'(COORD_MIN);
            PHASE_CAM_MIXED: cam[c] = (c == 0) ? coord_type'(COORD_MAX) :
                                      (c == 1) ? coord_type'(COORD_MIN) : '0;
            default:         cam[c] = coord_type'($urandom);
         endcase
      write_csr(tbc_pkg::CSR_CAMERA_X, cam[0]);
      write_csr(tbc_pkg::CSR_CAMERA_Y, cam[1]);
      write_csr(tbc_pkg::CSR_CAMERA_Z, cam[2]);
      // after the real ones, so a decode that aliases index 3 shows up
      write_csr(CSR_UNUSED_INDEX, coord_type'($urandom));
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Main sequence: reset, directed table at the reset camera, then
   // random phases, each behind a fresh camera setting.
   // ------------------------------------------------------------------
   initial begin : stimulus
      cull_result_type want;
      triangle_type    t;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      directed_rows = '{
         // zero-area at origin, also eye on v0 with camera at reset
         row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0),
         // zero-area on each rail
         row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
             COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 0, 0, 0, 1'b0),
         row(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
             COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 0, 0, 0, 1'b0),
         // unit +z normal, eye along +z: facing away, culled
         row(0, 0, 5, 1, 0, 5, 0, 1, 5, 1'b1, 0, 0, 1, 1'b1),
         // same triangle wound the other way
         row(0, 0, 5, 0, 1, 5, 1, 0, 5, 1'b1, 0, 0, -1, 1'b0),
         // eye in the triangle plane, dot exactly zero
         row(5, 0, 0, 6, 0, 0, 5, 1, 0, 1'b1, 0, 0, 1, 1'b0),
         // eye on v0, nonzero normal
         row(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b1, 0, 0, 1, 1'b0),
         // unit normals along x and y
         row(7, 0, 0, 7, 1, 0, 7, 0, 1, 1'b1, 1, 0, 0, 1'b1),
         row(0, -3, 0, 0, -3, 1, 1, -3, 0, 1'b1, 0, 1, 0, 1'b0),
         // full-swing edges, predictor checked
         row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
             COORD_MAX, COORD_MIN, COORD_MIN),
         row(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
             COORD_MIN, COORD_MAX, COORD_MAX),
         row(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
             COORD_MAX, COORD_MAX, COORD_MIN),
         row(COORD_MIN, COORD_MAX, 0, COORD_MAX, COORD_MIN, COORD_MIN,
             COORD_MIN, COORD_MIN, COORD_MAX),
         row(1, -1, 1, -1, 1, -1, COORD_MAX, 0, COORD_MIN),
         row(-1, -1, -1, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX),
         row(100, 200, -300, -400, 500, 600, 700, -800, 900),
         row(COORD_MIN, 0, COORD_MAX, COORD_MAX, 0, COORD_MIN, 0, COORD_MAX, COORD_MIN)
      };

      foreach (directed_rows[i]) begin
         want = directed_rows[i].known ? directed_rows[i].result
                                       : predict_cull(directed_rows[i].vertices);
         send_triangle(directed_rows[i].vertices, want, draw_gap(req_burst));
      end

      for (int phase = 1; phase <= NUM_PHASES; phase++) begin
         // camera regs only change with nothing in flight
         drain_results();
         set_camera(phase);
         if (phase == PHASE_PRESSURE) hold_off_pending = 1'b1;
         for (int n = 0; n < TRIS_PER_PHASE; n++) begin
            t = random_triangle();
            // back to back during the long hold-off so the queue backs up
            send_triangle(t, predict_cull(t),
                          (phase == PHASE_PRESSURE) ? 0 : draw_gap(req_burst));
         end
      end

      drain_results();
      repeat (3 * DUT_LATENCY) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver side: random stall per result, one long hold-off on request.
   // ------------------------------------------------------------------
   initial begin : rsp_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end else begin
            stall = draw_gap(rsp_burst);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Result check: every rsp_ transfer against the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      cull_result_type                                             want;
      logic [tbc_pkg::NUM_NORMALS-1:0][tbc_pkg::NORMAL_WIDTH-1:0]  got_normal;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_normal = rsp_tdata[tbc_pkg::NUM_NORMALS*tbc_pkg::NORMAL_WIDTH-1:0];
         if (pending_culls.size() == 0) begin
            report_mismatch("result with no triangle outstanding");
         end else begin
            want = pending_culls.pop_front();
            for (int c = 0; c < tbc_pkg::NUM_NORMALS; c++)
               if (got_normal[c] !== want.normal[c])
                  report_mismatch($sformatf("normal_%s got %0d expected %0d", axis_name[c],
                                            $signed(got_normal[c]), $signed(want.normal[c])));
            if (rsp_tuser !== want.culled)
               report_mismatch($sformatf("culled got %b expected %b", rsp_tuser, want.culled));
         end
         checked_results++;
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long without a transfer on either side means a hang.
   // ------------------------------------------------------------------
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_culls.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
sv/tbc_pkg.sv
sv/tbc_front.sv
sv/tbc_queue.sv
sv/tbc_back.sv
sv/triangle_backface_cull.sv
dv/triangle_backface_cull_tb.sv
